/* rtl/adam_parameter_update_defines.svh */
// Assertion macros for the Adam parameter update block.
// Included by the top level; no other dependencies.
`ifndef ADAM_PARAMETER_UPDATE_DEFINES_SVH
`define ADAM_PARAMETER_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define ADU_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ADU_ASSERT_CLK(lbl, prop, msg)
`define ADU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/adu_pkg.sv */
// Shared types and constants of the Adam parameter update block.
// No dependencies; imported by every module of the block.
package adu_pkg;

  localparam int unsigned QF = 24;
  localparam logic [24:0] ONE_Q24 = 25'd16777216;
  localparam logic [23:0] HALF_Q24 = 24'd8388608;
  localparam logic [37:0] MHAT_CAP = '1;
  localparam logic [39:0] VHAT_CAP = '1;
  localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

  localparam int unsigned IN_TDATA_W = 128;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 25;

  // long divider: one quotient bit per stage
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DEN_W = 33;

  // square root: one root bit per stage
  localparam int unsigned SQ_IN_W = 64;
  localparam int unsigned SQ_W = 32;
  localparam int unsigned SQ_REM_W = 34;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 3'd0,
    CFG_ALPHA = 3'd1,
    CFG_BETA1 = 3'd2,
    CFG_BETA2 = 3'd3,
    CFG_EPS   = 3'd4,
    CFG_BATCH = 3'd5
  } cfg_idx_t;

  // one element in flight; later stages fill in their fields
  typedef struct packed {
    logic               neg;
    logic signed [31:0] m_in;
    logic [30:0]        v_in;
    logic signed [31:0] p_in;
    logic [24:0]        d1;
    logic [24:0]        d2;
    logic signed [31:0] g;
    logic signed [57:0] plain_t;
    logic signed [31:0] newm;
    logic [30:0]        newv;
    logic               flag;
    logic               m_neg;
    logic [37:0]        mhat;
    logic [DEN_W-1:0]   den;
  } item_t;

endpackage

/* rtl/adu_div.sv */
// Pipelined unsigned long divider, one quotient bit per register stage.
// Depends on adu_pkg for widths and the item type carried alongside.
module adu_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  adu_pkg::item_t              in_item,
  input  logic [adu_pkg::DIV_W-1:0]   in_dividend,
  input  logic [adu_pkg::DEN_W-1:0]   in_divisor,
  output logic                        out_valid,
  output adu_pkg::item_t              out_item,
  output logic [adu_pkg::DIV_W-1:0]   out_quotient
);
  import adu_pkg::*;

  logic             vld_r [DIV_W];
  item_t            itm_r [DIV_W];
  logic [DEN_W-1:0] rem_r [DIV_W];
  logic [DEN_W-1:0] dsr_r [DIV_W];
  logic [DIV_W-1:0] x_r   [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic             v_in;
    item_t            i_in;
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [DIV_W-1:0] x_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_head
      assign v_in = in_valid;
      assign i_in = in_item;
      assign r_in = '0;
      assign d_in = in_divisor;
      assign x_in = in_dividend;
    end else begin : g_body
      assign v_in = vld_r[k-1];
      assign i_in = itm_r[k-1];
      assign r_in = rem_r[k-1];
      assign d_in = dsr_r[k-1];
      assign x_in = x_r[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_in, x_in[DIV_W-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itm_r[k] <= i_in;
        dsr_r[k] <= d_in;
        rem_r[k] <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
        x_r[k]   <= {x_in[DIV_W-2:0], ge};
      end
    end
  end

  assign out_valid    = vld_r[DIV_W-1];
  assign out_item     = itm_r[DIV_W-1];
  assign out_quotient = x_r[DIV_W-1];

endmodule

/* rtl/adu_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Depends on adu_pkg for widths and the item type carried alongside.
module adu_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  adu_pkg::item_t                in_item,
  input  logic [adu_pkg::SQ_IN_W-1:0]   in_radicand,
  output logic                          out_valid,
  output adu_pkg::item_t                out_item,
  output logic [adu_pkg::SQ_W-1:0]      out_root
);
  import adu_pkg::*;

  logic                vld_r  [SQ_W];
  item_t               itm_r  [SQ_W];
  logic [SQ_REM_W-1:0] rem_r  [SQ_W];
  logic [SQ_W-1:0]     root_r [SQ_W];
  logic [SQ_IN_W-1:0]  x_r    [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    logic                v_in;
    item_t               i_in;
    logic [SQ_REM_W-1:0] r_in;
    logic [SQ_W-1:0]     q_in;
    logic [SQ_IN_W-1:0]  x_in;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] t;
    logic                ge;

    if (k == 0) begin : g_head
      assign v_in = in_valid;
      assign i_in = in_item;
      assign r_in = '0;
      assign q_in = '0;
      assign x_in = in_radicand;
    end else begin : g_body
      assign v_in = vld_r[k-1];
      assign i_in = itm_r[k-1];
      assign r_in = rem_r[k-1];
      assign q_in = root_r[k-1];
      assign x_in = x_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign trial = {r_in, x_in[SQ_IN_W-1 -: 2]};
    assign t     = {2'b00, q_in, 2'b01};
    assign ge    = trial >= t;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itm_r[k]  <= i_in;
        rem_r[k]  <= ge ? SQ_REM_W'(trial - t) : trial[SQ_REM_W-1:0];
        root_r[k] <= {q_in[SQ_W-2:0], ge};
        x_r[k]    <= {x_in[SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld_r[SQ_W-1];
  assign out_item  = itm_r[SQ_W-1];
  assign out_root  = root_r[SQ_W-1];

endmodule

/* rtl/adam_parameter_update.sv */
// Adam parameter update: top level with configuration registers and stages.
// Depends on adu_pkg, adu_div, adu_sqrt and adam_parameter_update_defines.svh.
//
// Usage: stream one parameter element per beat on the in_ channel (tdata holds
// grad_sum, first_moment, second_moment, param_value; tuser flags the first
// element of an update pass). Each input beat produces exactly one out_ beat
// with the updated parameter, both moments and a saturation flag.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// the user must write them only while no element is in flight; the block itself
// does not enforce this. cfg_ready is always high. Throughput: one element per
// cycle while the receiver does not stall. The pipeline has 231 register stages:
// the chain of three 64-stage long dividers (gradient/batch, bias correction,
// step), the 32-stage square root and seven arithmetic register stages.
// The whole pipeline advances on a single enable: it moves whenever the output
// register is empty or being taken. When the receiver stalls with a result
// held, every stage holds and in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits, loads the
// registers with their defaults and sets both decay powers to 1.0.
// Decay powers advance on the first element of each pass in Adam mode.
`include "adam_parameter_update_defines.svh"
module adam_parameter_update (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // grad_sum[31:0], first_moment[63:32], second_moment[94:64], param_value[126:95]
  input  logic [adu_pkg::IN_TDATA_W-1:0]     in_tdata,
  // first_of_pass[0]
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // new_param[31:0], new_first_moment[63:32], new_second_moment[94:64]
  output logic [adu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // saturated[0]
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adu_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import adu_pkg::*;

  // ---------------- configuration registers ----------------
  logic        mode_r;
  logic [24:0] alpha_r;
  logic [23:0] beta1_r;
  logic [23:0] beta2_r;
  logic [24:0] eps_r;
  logic [15:0] batch_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      alpha_r <= 25'd16777;
      beta1_r <= 24'd15099494;
      beta2_r <= 24'd16760439;
      eps_r   <= 25'd1;
      batch_r <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:  mode_r  <= cfg_data[0];
        CFG_ALPHA: alpha_r <= cfg_data;
        CFG_BETA1: beta1_r <= cfg_data[23:0];
        CFG_BETA2: beta2_r <= cfg_data[23:0];
        CFG_EPS:   eps_r   <= cfg_data;
        CFG_BATCH: batch_r <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // ---------------- global pipeline enable ----------------
  logic out_valid_r;
  logic en;
  logic accept;
  logic adv;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign adv       = accept && in_tuser[0] && mode_r;

  // ---------------- front: decay powers, dividend select ----------------
  logic [24:0] p1_r, p2_r;
  logic [48:0] p1_prod, p2_prod;
  logic [24:0] p1_adv, p2_adv, p1_use, p2_use;

  assign p1_prod = 49'(p1_r) * 49'(beta1_r);
  assign p2_prod = 49'(p2_r) * 49'(beta2_r);
  assign p1_adv  = 25'((p1_prod + 49'(HALF_Q24)) >> QF);
  assign p2_adv  = 25'((p2_prod + 49'(HALF_Q24)) >> QF);
  assign p1_use  = adv ? p1_adv : p1_r;
  assign p2_use  = adv ? p2_adv : p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= ONE_Q24;
      p2_r <= ONE_Q24;
    end else if (adv) begin
      p1_r <= p1_adv;
      p2_r <= p2_adv;
    end
  end

  logic signed [31:0] in_grad, in_m, in_p;
  logic [30:0]        in_v;
  logic [31:0]        grad_mag;
  logic [56:0]        alpha_prod;
  logic [15:0]        batch_eff;
  item_t              f_item;
  logic [DIV_W-1:0]   f_dividend;

  assign in_grad    = in_tdata[31:0];
  assign in_m       = in_tdata[63:32];
  assign in_v       = in_tdata[94:64];
  assign in_p       = in_tdata[126:95];
  assign grad_mag   = in_grad[31] ? 32'(-in_grad) : in_grad;
  assign alpha_prod = 57'(alpha_r) * 57'(grad_mag);
  assign batch_eff  = (batch_r == '0) ? 16'd1 : batch_r;
  // Adam divides the gradient, plain mode the scaled gradient
  assign f_dividend = mode_r ? DIV_W'(grad_mag) : DIV_W'(alpha_prod);

  always_comb begin
    f_item      = '0;
    f_item.neg  = in_grad[31];
    f_item.m_in = in_m;
    f_item.v_in = in_v;
    f_item.p_in = in_p;
    // no correction yet when the power has not dropped below 1.0
    f_item.d1   = (p1_use >= ONE_Q24) ? ONE_Q24 : ONE_Q24 - p1_use;
    f_item.d2   = (p2_use >= ONE_Q24) ? ONE_Q24 : ONE_Q24 - p2_use;
  end

  // ---------------- divider 1: gradient or scaled gradient over batch ----------------
  logic             d1_vld;
  item_t            d1_item;
  logic [DIV_W-1:0] d1_q;

  adu_div u_div_grad (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_tvalid),
    .in_item      (f_item),
    .in_dividend  (f_dividend),
    .in_divisor   (DEN_W'(batch_eff)),
    .out_valid    (d1_vld),
    .out_item     (d1_item),
    .out_quotient (d1_q)
  );

  // ---------------- M1: moment products ----------------
  logic signed [31:0] g_s;
  logic signed [24:0] b1_s;
  logic signed [25:0] f1_s;
  item_t              m1_item_nxt;

  assign g_s  = d1_item.neg ? 32'(-d1_q[31:0]) : d1_q[31:0];
  assign b1_s = $signed({1'b0, beta1_r});
  assign f1_s = $signed({1'b0, 25'(ONE_Q24 - 25'(beta1_r))});

  always_comb begin
    m1_item_nxt         = d1_item;
    m1_item_nxt.g       = g_s;
    m1_item_nxt.plain_t = d1_item.neg ? -$signed(58'(d1_q)) : $signed(58'(d1_q));
  end

  logic               m1_vld_r;
  item_t              m1_item_r;
  logic signed [56:0] m1_pm1_r, m1_pm2_r;
  logic [63:0]        m1_gg_r;
  logic [54:0]        m1_pv1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_item_r <= m1_item_nxt;
      m1_pm1_r  <= b1_s * $signed(d1_item.m_in);
      m1_pm2_r  <= f1_s * g_s;
      m1_gg_r   <= 64'(d1_q[31:0]) * 64'(d1_q[31:0]);
      m1_pv1_r  <= 55'(beta2_r) * 55'(d1_item.v_in);
    end
  end

  // ---------------- M2: first moment, squared gradient ----------------
  logic signed [57:0] sum_m;
  logic signed [33:0] newm_full;
  logic signed [31:0] newm_sat;
  logic               fm;
  logic [38:0]        gsq;
  logic [24:0]        f2;
  item_t              m2_item_nxt;

  assign sum_m     = 58'(m1_pm1_r) + 58'(m1_pm2_r) + $signed({34'd0, HALF_Q24});
  assign newm_full = $signed(sum_m[57:24]);
  assign gsq       = 39'((m1_gg_r + 64'(HALF_Q24)) >> QF);
  assign f2        = ONE_Q24 - 25'(beta2_r);

  always_comb begin
    fm       = 1'b0;
    newm_sat = newm_full[31:0];
    if (newm_full > 34'sd2147483647) begin
      fm       = 1'b1;
      newm_sat = 32'sh7FFF_FFFF;
    end else if (newm_full < -34'sd2147483648) begin
      fm       = 1'b1;
      newm_sat = 32'sh8000_0000;
    end
    m2_item_nxt      = m1_item_r;
    m2_item_nxt.newm = newm_sat;
    m2_item_nxt.flag = fm;
  end

  logic        m2_vld_r;
  item_t       m2_item_r;
  logic [54:0] m2_pv1_r;
  logic [43:0] m2_pvlo_r;
  logic [44:0] m2_pvhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_item_r <= m2_item_nxt;
      m2_pv1_r  <= m1_pv1_r;
      m2_pvlo_r <= 44'(f2) * 44'(gsq[18:0]);
      m2_pvhi_r <= 45'(f2) * 45'(gsq[38:19]);
    end
  end

  // ---------------- M3: second moment, correction dividends ----------------
  logic [63:0] vsum;
  logic [39:0] newv_full;
  logic        fv;
  logic [30:0] newv_sat;
  logic [31:0] m_mag;
  item_t       m3_item_nxt;

  assign vsum = 64'(m2_pv1_r) + (64'(m2_pvhi_r) << 19) + 64'(m2_pvlo_r)
              + 64'(HALF_Q24);
  assign newv_full = vsum[63:24];
  assign fv        = |newv_full[39:31];
  assign newv_sat  = fv ? '1 : newv_full[30:0];
  assign m_mag     = m2_item_r.newm[31] ? 32'(-m2_item_r.newm) : m2_item_r.newm;

  always_comb begin
    m3_item_nxt       = m2_item_r;
    m3_item_nxt.newv  = newv_sat;
    m3_item_nxt.flag  = m2_item_r.flag | fv;
    m3_item_nxt.m_neg = m2_item_r.newm[31];
  end

  logic             m3_vld_r;
  item_t            m3_item_r;
  logic [DIV_W-1:0] m3_mdiv_r, m3_vdiv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_item_r <= m3_item_nxt;
      m3_mdiv_r <= {8'd0, m_mag, 24'd0};
      m3_vdiv_r <= {9'd0, newv_sat, 24'd0};
    end
  end

  // ---------------- divider 2: bias correction ----------------
  logic             d2_vld;
  item_t            d2_item;
  logic [DIV_W-1:0] d2_qm, d2_qv;

  adu_div u_div_mhat (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (m3_vld_r),
    .in_item      (m3_item_r),
    .in_dividend  (m3_mdiv_r),
    .in_divisor   (DEN_W'(m3_item_r.d1)),
    .out_valid    (d2_vld),
    .out_item     (d2_item),
    .out_quotient (d2_qm)
  );

  adu_div u_div_vhat (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (m3_vld_r),
    .in_item      (m3_item_r),
    .in_dividend  (m3_vdiv_r),
    .in_divisor   (DEN_W'(m3_item_r.d2)),
    .out_valid    (),
    .out_item     (),
    .out_quotient (d2_qv)
  );

  // ---------------- H: clip corrected moments ----------------
  logic               h_vld_r;
  item_t              h_item_r;
  logic [SQ_IN_W-1:0] h_rad_r;
  item_t              h_item_nxt;
  logic [39:0]        vhat;

  assign vhat = (d2_qv > 64'(VHAT_CAP)) ? VHAT_CAP : d2_qv[39:0];

  always_comb begin
    h_item_nxt      = d2_item;
    h_item_nxt.mhat = (d2_qm > 64'(MHAT_CAP)) ? MHAT_CAP : d2_qm[37:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_item_r <= h_item_nxt;
      h_rad_r  <= {vhat, 24'd0};
    end
  end

  // ---------------- square root of corrected second moment ----------------
  logic            sq_vld;
  item_t           sq_item;
  logic [SQ_W-1:0] sq_root;

  adu_sqrt u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (h_vld_r),
    .in_item     (h_item_r),
    .in_radicand (h_rad_r),
    .out_valid   (sq_vld),
    .out_item    (sq_item),
    .out_root    (sq_root)
  );

  // ---------------- S1: denominator, split numerator products ----------------
  logic [DEN_W-1:0] den_raw;
  item_t            s1_item_nxt;

  assign den_raw = DEN_W'(sq_root) + DEN_W'(eps_r);

  always_comb begin
    s1_item_nxt     = sq_item;
    // zero denominator only with zero epsilon and zero root
    s1_item_nxt.den = (den_raw == '0) ? DEN_W'(1) : den_raw;
  end

  logic        s1_vld_r;
  item_t       s1_item_r;
  logic [43:0] s1_nlo_r, s1_nhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= s1_item_nxt;
      s1_nlo_r  <= 44'(alpha_r) * 44'(sq_item.mhat[18:0]);
      s1_nhi_r  <= 44'(alpha_r) * 44'(sq_item.mhat[37:19]);
    end
  end

  // ---------------- S2: combine numerator ----------------
  logic             s2_vld_r;
  item_t            s2_item_r;
  logic [DIV_W-1:0] s2_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_item_r <= s1_item_r;
      s2_num_r  <= (DIV_W'(s1_nhi_r) << 19) + DIV_W'(s1_nlo_r);
    end
  end

  // ---------------- divider 3: step size ----------------
  logic             d3_vld;
  item_t            d3_item;
  logic [DIV_W-1:0] d3_q;

  adu_div u_div_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (s2_vld_r),
    .in_item      (s2_item_r),
    .in_dividend  (s2_num_r),
    .in_divisor   (s2_item_r.den),
    .out_valid    (d3_vld),
    .out_item     (d3_item),
    .out_quotient (d3_q)
  );

  // ---------------- output stage: parameter add and saturate ----------------
  logic [40:0]        step_mag;
  logic signed [41:0] adam_step;
  logic signed [57:0] plain_sum;
  logic signed [33:0] plain_step;
  logic signed [41:0] step_sel;
  logic signed [42:0] newp_full;
  logic signed [31:0] newp_sat;
  logic               fp;

  assign step_mag   = (d3_q > 64'(STEP_CAP)) ? STEP_CAP : d3_q[40:0];
  assign adam_step  = d3_item.m_neg ? -$signed({1'b0, step_mag})
                                    : $signed({1'b0, step_mag});
  assign plain_sum  = d3_item.plain_t + $signed({34'd0, HALF_Q24});
  assign plain_step = $signed(plain_sum[57:24]);
  assign step_sel   = mode_r ? adam_step : 42'(plain_step);
  assign newp_full  = 43'(d3_item.p_in) + 43'(step_sel);

  always_comb begin
    fp       = 1'b0;
    newp_sat = newp_full[31:0];
    if (newp_full > 43'sd2147483647) begin
      fp       = 1'b1;
      newp_sat = 32'sh7FFF_FFFF;
    end else if (newp_full < -43'sd2147483648) begin
      fp       = 1'b1;
      newp_sat = 32'sh8000_0000;
    end
  end

  logic signed [31:0] out_p_r, out_m_r;
  logic [30:0]        out_v_r;
  logic               out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p_r   <= newp_sat;
      // plain mode passes the stored moments through unchanged
      out_m_r   <= mode_r ? d3_item.newm : d3_item.m_in;
      out_v_r   <= mode_r ? d3_item.newv : d3_item.v_in;
      out_sat_r <= (mode_r & d3_item.flag) | fp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_v_r, out_m_r, out_p_r};
  assign out_tuser  = out_sat_r;

  // ---------------- assertions ----------------
  `ADU_ASSERT_CLK(a_power_hold, !(in_tvalid && in_tready && in_tuser[0]) |=> $stable(p1_r) && $stable(p2_r), "decay power moved without a first-of-pass beat")
  `ADU_ASSERT_NEVER(a_power_range, (p1_r > ONE_Q24) || (p2_r > ONE_Q24), "decay power above 1.0")
  `ADU_ASSERT_CLK(a_sat_flag, (out_tvalid && out_tuser[0]) |-> (out_p_r == 32'sh7FFF_FFFF || out_p_r == 32'sh8000_0000 || out_m_r == 32'sh7FFF_FFFF || out_m_r == 32'sh8000_0000 || out_v_r == '1), "saturation flag without a clipped result")

endmodule
